### rtl/tfn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg: shared widths and constants of the triangle face normal block
// Fixed-point widths of every pipeline quantity, from Q6.12 corners to the
// Q1.14 unit normal.
// ----------------------------------------------------------------------------
package tfn_pkg;

    // corner coordinates, Q6.12
    localparam int COORD_W = 18;
    // edge vectors, one bit wider than a coordinate
    localparam int EDGE_W  = COORD_W + 1;
    // edge products and cross product components, Q.24
    localparam int PROD_W  = 2 * EDGE_W;
    // magnitude of a cross product component
    localparam int PMAG_W  = PROD_W - 1;
    // split of a magnitude for the squaring partial products
    localparam int LO_W    = 20;
    localparam int HI_W    = PMAG_W - LO_W;
    localparam int SQ_W    = 2 * PMAG_W;
    // sum of three squares
    localparam int SUM_W   = SQ_W + 2;
    // integer square root and its trial width
    localparam int ROOT_W  = SUM_W / 2;
    localparam int TRY_W   = SUM_W + 1;
    // divider operands and quotient
    localparam int DEN_W   = ROOT_W + 1;
    localparam int QUO_W   = 15;
    localparam int NUM_W   = PMAG_W + QUO_W + 2;
    // result format
    localparam int OUT_W   = 16;
    localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);
    // threshold register
    localparam int CFG_W   = 32;
    localparam int THR_W   = 2 * CFG_W;
    localparam logic [THR_W-1:0] MIN_LEN_SQ_RESET = THR_W'(289);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]   comp_t;

endpackage : tfn_pkg
`default_nettype wire

### rtl/tfn_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_in_if: triangle input channel
// Valid/ready channel carrying the three corners of one triangle.
// ----------------------------------------------------------------------------
interface tfn_in_if;
    import tfn_pkg::*;

    logic   valid;
    logic   ready;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;

    modport source (output valid, output ax, output ay, output az, output bx,
                    output by, output bz, output cx, output cy, output cz,
                    input ready);
    modport sink   (input valid, input ax, input ay, input az, input bx,
                    input by, input bz, input cx, input cy, input cz,
                    output ready);
endinterface : tfn_in_if
`default_nettype wire

### rtl/tfn_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_out_if: face normal output channel
// Valid/ready channel carrying one Q1.14 unit normal and its degenerate flag.
// ----------------------------------------------------------------------------
interface tfn_out_if;
    import tfn_pkg::*;

    logic  valid;
    logic  ready;
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degenerate;

    modport source (output valid, output nx, output ny, output nz,
                     output degenerate, input ready);
    modport sink   (input valid, input nx, input ny, input nz,
                    input degenerate, output ready);
endinterface : tfn_out_if
`default_nettype wire

### rtl/tfn_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_divider: pipelined restoring divider
// One quotient bit per stage, QUO_W stages; the whole pipe advances on en.
// ----------------------------------------------------------------------------
module tfn_divider
    import tfn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int K = QUO_W - 1 - j;
        logic [NUM_W-1:0] cur_rem;
        logic [DEN_W-1:0] cur_den;
        logic [QUO_W-1:0] cur_quo;
        logic [NUM_W-1:0] shifted;
        logic             take;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        // stage source: ports for the first step, previous stage otherwise
        if (j == 0) begin : g_first
            assign cur_rem = num;
            assign cur_den = den;
            assign cur_quo = '0;
        end
        else begin : g_mid
            assign cur_rem = rem_reg[j-1];
            assign cur_den = den_reg[j-1];
            assign cur_quo = quo_reg[j-1];
        end

        // compare and subtract the shifted divisor
        assign shifted  = NUM_W'(cur_den) << K;
        assign take     = cur_rem >= shifted;
        assign rem_next = take ? (cur_rem - shifted) : cur_rem;
        assign quo_next = take ? (cur_quo | (QUO_W'(1) << K)) : cur_quo;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= cur_den;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule : tfn_divider
`default_nettype wire

### rtl/triangle_face_normal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of a triangle
// Cross product of the edges from corner a, exact length test, square root and
// a divider per component give the Q1.14 unit normal or a degenerate flag.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle is accepted every clock cycle while the pipe
// advances, and its normal passes the edge, product and square-sum stages,
// 38 square root stages of one root bit each, 1 operand stage, 15 divider
// stages of one quotient bit each and 1 output register. The whole pipe
// advances together; it holds only while a finished normal waits on the
// output and the sink is not ready. A threshold write takes effect on the
// following cycle and is meant to happen while the pipe is empty.
module triangle_face_normal
    import tfn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    tfn_in_if.sink                vertices,
    tfn_out_if.source             normal,
    input  wire logic             cfg_wen,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic en;
    logic [THR_W-1:0] min_len_sq_reg;

    // pipe advances unless a result is held on the output
    assign en             = !normal.valid || normal.ready;
    assign vertices.ready = en;

    // threshold kept as its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_sq_reg <= MIN_LEN_SQ_RESET;
        else if (cfg_wen)
            min_len_sq_reg <= THR_W'(cfg_wdata * cfg_wdata);
    end

    // ---------------- stage 1: edges
    logic                     s1_vld_reg;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= vertices.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= EDGE_W'(vertices.bx) - EDGE_W'(vertices.ax);
            e1_reg[1] <= EDGE_W'(vertices.by) - EDGE_W'(vertices.ay);
            e1_reg[2] <= EDGE_W'(vertices.bz) - EDGE_W'(vertices.az);
            e2_reg[0] <= EDGE_W'(vertices.cx) - EDGE_W'(vertices.ax);
            e2_reg[1] <= EDGE_W'(vertices.cy) - EDGE_W'(vertices.ay);
            e2_reg[2] <= EDGE_W'(vertices.cz) - EDGE_W'(vertices.az);
        end
    end

    // ---------------- stage 2: edge products
    logic                     s2_vld_reg;
    logic signed [PROD_W-1:0] mp_reg [3];
    logic signed [PROD_W-1:0] mn_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_reg[0] <= PROD_W'(e1_reg[1] * e2_reg[2]);
            mn_reg[0] <= PROD_W'(e1_reg[2] * e2_reg[1]);
            mp_reg[1] <= PROD_W'(e1_reg[2] * e2_reg[0]);
            mn_reg[1] <= PROD_W'(e1_reg[0] * e2_reg[2]);
            mp_reg[2] <= PROD_W'(e1_reg[0] * e2_reg[1]);
            mn_reg[2] <= PROD_W'(e1_reg[1] * e2_reg[0]);
        end
    end

    // ---------------- stage 3: cross product as magnitude and sign
    logic                     s3_vld_reg;
    logic        [PMAG_W-1:0] s3_mag_reg [3];
    logic                     s3_neg_reg [3];
    logic signed [PROD_W-1:0] cp_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cp_next[i] = mp_reg[i] - mn_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_neg_reg[i] <= cp_next[i][PROD_W-1];
                s3_mag_reg[i] <= cp_next[i][PROD_W-1] ? PMAG_W'(-cp_next[i])
                                                      : PMAG_W'(cp_next[i]);
            end
        end
    end

    // ---------------- stage 4: squaring partial products
    logic                      s4_vld_reg;
    logic [PMAG_W-1:0]         s4_mag_reg [3];
    logic                      s4_neg_reg [3];
    logic [2*HI_W-1:0]         hh_reg [3];
    logic [HI_W+LO_W-1:0]      hl_reg [3];
    logic [2*LO_W-1:0]         ll_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_mag_reg[i] <= s3_mag_reg[i];
                s4_neg_reg[i] <= s3_neg_reg[i];
                hh_reg[i] <= s3_mag_reg[i][PMAG_W-1:LO_W] * s3_mag_reg[i][PMAG_W-1:LO_W];
                hl_reg[i] <= s3_mag_reg[i][PMAG_W-1:LO_W] * s3_mag_reg[i][LO_W-1:0];
                ll_reg[i] <= s3_mag_reg[i][LO_W-1:0] * s3_mag_reg[i][LO_W-1:0];
            end
        end
    end

    // ---------------- stage 5: squares
    logic              s5_vld_reg;
    logic [PMAG_W-1:0] s5_mag_reg [3];
    logic              s5_neg_reg [3];
    logic [SQ_W-1:0]   sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (en)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_mag_reg[i] <= s4_mag_reg[i];
                s5_neg_reg[i] <= s4_neg_reg[i];
                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * LO_W))
                           + (SQ_W'(hl_reg[i]) << (LO_W + 1))
                           + SQ_W'(ll_reg[i]);
            end
        end
    end

    // ---------------- stage 6: sum of squares and threshold test
    logic              rt_vld_reg  [ROOT_W+1];
    logic              rt_deg_reg  [ROOT_W+1];
    logic [SUM_W-1:0]  rt_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] rt_root_reg [ROOT_W+1];
    logic [PMAG_W-1:0] rt_mag_reg  [ROOT_W+1][3];
    logic              rt_neg_reg  [ROOT_W+1][3];
    logic [SUM_W-1:0]  sum_next;

    assign sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_vld_reg[0] <= 1'b0;
        else if (en)
            rt_vld_reg[0] <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_rem_reg[0]  <= sum_next;
            rt_root_reg[0] <= '0;
            rt_deg_reg[0]  <= !(sum_next > SUM_W'(min_len_sq_reg));
            for (int i = 0; i < 3; i++)
            begin
                rt_mag_reg[0][i] <= s5_mag_reg[i];
                rt_neg_reg[0][i] <= s5_neg_reg[i];
            end
        end
    end

    // ---------------- square root, one root bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        localparam int B = ROOT_W - 1 - j;
        logic [TRY_W-1:0]  trial;
        logic [TRY_W-1:0]  rem_ext;
        logic              take;
        logic [SUM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        assign trial     = (TRY_W'(rt_root_reg[j]) << (B + 1)) | (TRY_W'(1) << (2 * B));
        assign rem_ext   = TRY_W'(rt_rem_reg[j]);
        assign take      = rem_ext >= trial;
        assign rem_next  = take ? SUM_W'(rem_ext - trial) : rt_rem_reg[j];
        assign root_next = take ? (rt_root_reg[j] | (ROOT_W'(1) << B)) : rt_root_reg[j];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_vld_reg[j+1] <= 1'b0;
            else if (en)
                rt_vld_reg[j+1] <= rt_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_rem_reg[j+1]  <= rem_next;
                rt_root_reg[j+1] <= root_next;
                rt_deg_reg[j+1]  <= rt_deg_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    rt_mag_reg[j+1][i] <= rt_mag_reg[j][i];
                    rt_neg_reg[j+1][i] <= rt_neg_reg[j][i];
                end
            end
        end
    end

    // ---------------- divider operands and sideband delay line
    logic             dv_vld_reg [QUO_W+1];
    logic             dv_deg_reg [QUO_W+1];
    logic             dv_neg_reg [QUO_W+1][3];
    logic [NUM_W-1:0] num_reg [3];
    logic [DEN_W-1:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= rt_vld_reg[ROOT_W];
    end

    // numerator |p| * 32768 + len, denominator 2 * len
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_deg_reg[0] <= rt_deg_reg[ROOT_W];
            den_reg       <= {rt_root_reg[ROOT_W], 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                dv_neg_reg[0][i] <= rt_neg_reg[ROOT_W][i];
                num_reg[i] <= (NUM_W'(rt_mag_reg[ROOT_W][i]) << QUO_W)
                            + NUM_W'(rt_root_reg[ROOT_W]);
            end
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else if (en)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_deg_reg[j+1] <= dv_deg_reg[j];
                for (int i = 0; i < 3; i++)
                    dv_neg_reg[j+1][i] <= dv_neg_reg[j][i];
            end
        end
    end

    // ---------------- three component dividers
    logic [QUO_W-1:0] quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        tfn_divider u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    // ---------------- output register: saturate, sign, degenerate zero
    logic  out_vld_reg;
    logic  out_deg_reg;
    comp_t out_reg [3];
    comp_t comp_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QUO_W-1:0] sat;
            sat = (quo[i] > ONE_Q14) ? ONE_Q14 : quo[i];
            if (dv_deg_reg[QUO_W])
                comp_next[i] = '0;
            else if (dv_neg_reg[QUO_W][i])
                comp_next[i] = comp_t'(-$signed({1'b0, sat}));
            else
                comp_next[i] = comp_t'({1'b0, sat});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_deg_reg <= dv_deg_reg[QUO_W];
            for (int i = 0; i < 3; i++)
                out_reg[i] <= comp_next[i];
        end
    end

    assign normal.valid      = out_vld_reg;
    assign normal.nx         = out_reg[0];
    assign normal.ny         = out_reg[1];
    assign normal.nz         = out_reg[2];
    assign normal.degenerate = out_deg_reg;

    // ---------------- assertions
    // a degenerate triangle leaves as a zero vector
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (normal.valid && normal.degenerate) |->
            (normal.nx == 0 && normal.ny == 0 && normal.nz == 0))
        else $error("degenerate normal is not zero");

    // unit components stay within plus and minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (normal.valid && !normal.degenerate) |->
            (normal.nx <= 16384 && normal.nx >= -16384 &&
             normal.ny <= 16384 && normal.ny >= -16384 &&
             normal.nz <= 16384 && normal.nz >= -16384))
        else $error("normal component out of range");

    // the finished root is the floor square root: remainder at most twice it
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        rt_vld_reg[ROOT_W] |->
            (TRY_W'(rt_rem_reg[ROOT_W]) <= (TRY_W'(rt_root_reg[ROOT_W]) << 1)))
        else $error("square root remainder too large");

    // a held result stalls the whole pipe, so nothing enters meanwhile
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (normal.valid && !normal.ready) |=> $stable(out_reg[0]) && $stable(s1_vld_reg))
        else $error("pipe moved while output stalled");

endmodule : triangle_face_normal
`default_nettype wire
